// ===== rtl/bab_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bab_pkg
// Shared types, sizes and codes for the bucketed address blocklist.
// ----------------------------------------------------------------------------
package bab_pkg;

    localparam int BUCKETS = 256;
    localparam int WAYS    = 16;
    localparam int ADDR_W  = 32;
    localparam int BIDX_W  = $clog2(BUCKETS);
    localparam int SLOT_W  = $clog2(WAYS);
    localparam int MODE_W  = 2;
    localparam int OCTET_CODES = 256;

    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [BIDX_W-1:0] bucket;
        logic [ADDR_W-1:0] address;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]            slot;
        logic [WAYS-1:0][ADDR_W-1:0]  ways;
    } row_t;

    typedef logic [OCTET_CODES-1:0][BIDX_W-1:0] bucket_lut_t;

    function automatic bucket_lut_t build_bucket_lut();
        bucket_lut_t lut;
        for (int i = 0; i < OCTET_CODES; i++) begin
            lut[i] = BIDX_W'(i % BUCKETS);
        end
        return lut;
    endfunction

    localparam bucket_lut_t BUCKET_LUT = build_bucket_lut();

endpackage
`default_nettype wire

// ===== rtl/bab_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bab_front
// Accepts input beats, decodes the mode and picks the bucket.
// ----------------------------------------------------------------------------
module bab_front import bab_pkg::*; (
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [ADDR_W-1:0] s_tdata,
    input  wire logic [MODE_W-1:0] s_tuser,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output item_t                  push_item
);

    logic [1:0] op;

    always_comb begin
        case (s_tuser)
            MODE_CHECK: op = OP_CHECK;
            MODE_ADD:   op = OP_ADD;
            MODE_CLEAR: op = OP_CLEAR;
            default:    op = OP_NONE;
        endcase
    end

    assign s_tready          = push_ready;
    assign push_valid        = s_tvalid;
    assign push_item.op      = op;
    assign push_item.bucket  = BUCKET_LUT[s_tdata[7:0]];
    assign push_item.address = s_tdata;

endmodule
`default_nettype wire

// ===== rtl/bab_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bab_queue
// Two-entry queue of decoded items between front and back.
// ----------------------------------------------------------------------------
module bab_queue import bab_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire item_t push_item,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output item_t      pop_item
);

    item_t      slots_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bab_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bab_back
// Bucket row memory, way compare, round-robin insert and result register.
// ----------------------------------------------------------------------------
module bab_back import bab_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  pop_valid,
    output logic       pop_ready,
    input  wire item_t pop_item,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [7:0] m_tdata  // bit 0 drop, bit 1 added, rest zero
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    row_t               mem [BUCKETS];
    logic               state_reg, state_next;
    logic [BUCKETS-1:0] valid_reg, valid_next;
    row_t               rd_row_reg;
    logic               rd_valid_reg;
    item_t              cur_reg;
    logic               out_valid_reg, out_valid_next;
    logic               drop_reg, drop_next;
    logic               added_reg, added_next;

    row_t              row, wr_row;
    logic [WAYS-1:0]   match;
    logic              hit;
    logic              pop;
    logic              look;
    logic              mem_we;

    assign pop       = (state_reg == S_IDLE) && pop_valid && (!out_valid_reg || m_tready);
    assign pop_ready = pop;
    assign look      = (state_reg == S_LOOK);

    always_comb begin
        row = rd_valid_reg ? rd_row_reg : '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = (row.ways[w] == cur_reg.address);
        end
        hit         = |match;
        wr_row      = row;
        wr_row.ways[row.slot] = cur_reg.address;
        wr_row.slot = (row.slot == SLOT_W'(WAYS - 1)) ? '0 : row.slot + SLOT_W'(1);
        mem_we      = look && (cur_reg.op == OP_ADD) && !hit;
    end

    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        drop_next      = drop_reg;
        added_next     = added_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                drop_next      = (cur_reg.op == OP_CHECK) && hit;
                added_next     = mem_we;
                if (mem_we) begin
                    valid_next[cur_reg.bucket] = 1'b1;
                end
                if (cur_reg.op == OP_CLEAR) begin
                    valid_next = '0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        drop_reg  <= drop_next;
        added_reg <= added_next;
        if (pop) begin
            cur_reg      <= pop_item;
            rd_valid_reg <= valid_reg[pop_item.bucket];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cur_reg.bucket] <= wr_row;
        end
        if (pop) begin
            rd_row_reg <= mem[pop_item.bucket];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, added_reg, drop_reg};

    a_look_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        look |-> $past(pop))
        else $error("lookup without a pop");

    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> !out_valid_reg)
        else $error("result register busy when lookup lands");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(drop_reg && added_reg))
        else $error("drop and added both set");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (look && cur_reg.op == OP_CLEAR) |=> (valid_reg == '0))
        else $error("clear left a bucket valid");

endmodule
`default_nettype wire

// ===== rtl/bucketed_address_blocklist_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_address_blocklist_top
// IPv4 source blocklist in 256 buckets of 16 ways with round-robin insert.
//
// channel  dir  tdata                tuser
// s_       in   address[31:0]        mode[1:0]
// m_       out  drop[0], added[1]    -
//
// in the back end each beat gets a registered bucket row read,
// then way compare and row write-back in the next cycle
// a two-entry queue lets input beats land while a result waits on m_tready
// clear drops all per-bucket valid bits at once; reset does the same,
// no clearing pass
// ----------------------------------------------------------------------------
module bucketed_address_blocklist_top import bab_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [ADDR_W-1:0] s_tdata,  // address
    input  wire logic [MODE_W-1:0] s_tuser,  // mode
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata   // drop, added, zero fill
);

    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    bab_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    bab_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    bab_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
